// File: design/block_bitmap_allocator_defines.svh
// assertion macros shared by the block bitmap allocator rtl
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define BBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba assertion failed");

// next-cycle implication, checked on clk outside reset
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba assertion failed");

`endif

// File: design/bba_pkg.sv
// shared constants, types and codes of the block bitmap allocator
package bba_pkg;

    localparam int MAX_BLOCKS  = 1024;
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_ADDR_W = $clog2(NUM_WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int STATUS_W    = 2;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);
    localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_BLOCKS);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } bba_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE
    } bba_state_t;

    // bitmap write request from the sequencer
    typedef struct packed {
        logic                   en;
        logic                   set;
        logic [WORD_ADDR_W-1:0] addr;
        logic [BIT_W-1:0]       bit_idx;
    } bba_wr_t;

endpackage

// File: design/bba_req_if.sv
// request channel: valid, ready and request word
interface bba_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [bba_pkg::IDX_W-1:0] free_index;

    modport source (output valid, output req_type, output free_index, input ready);
    modport sink (input valid, input req_type, input free_index, output ready);
endinterface

// File: design/bba_rsp_if.sv
// response channel: valid, ready and result word
interface bba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bba_pkg::IDX_W-1:0]    granted_index;
    logic [bba_pkg::STATUS_W-1:0] status;

    modport source (output valid, output granted_index, output status, input ready);
    modport sink (input valid, input granted_index, input status, output ready);
endinterface

// File: design/bba_word_store.sv
// used-block bitmap, one word read and one bit written per cycle
module bba_word_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bba_pkg::WORD_ADDR_W-1:0]     rd_addr,
    output logic [bba_pkg::WORD_BITS-1:0]       rd_data,
    input  bba_pkg::bba_wr_t                    wr
);

    logic [bba_pkg::WORD_BITS-1:0] words_reg [bba_pkg::NUM_WORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bba_pkg::NUM_WORDS; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            words_reg[wr.addr][wr.bit_idx] <= wr.set;
        end
    end

    assign rd_data = words_reg[rd_addr];

endmodule

// File: design/bba_first_free.sv
// lowest set bit of a word of candidate free blocks
module bba_first_free (
    input  logic [bba_pkg::WORD_BITS-1:0] cand,
    output logic                          found,
    output logic [bba_pkg::BIT_W-1:0]     bit_idx
);

    logic [bba_pkg::WORD_BITS-1:0] lowest;

    // isolate lowest set bit, then encode the one-hot result
    assign lowest = cand & (~cand + bba_pkg::WORD_BITS'(1));
    assign found  = |cand;

    always_comb
    begin
        bit_idx = '0;
        for (int i = 0; i < bba_pkg::WORD_BITS; i++)
        begin
            if (lowest[i])
            begin
                bit_idx = bit_idx | bba_pkg::BIT_W'(i);
            end
        end
    end

endmodule

// File: design/bba_seq.sv
// request sequencer: word-by-word allocate scan, free, result register
`include "block_bitmap_allocator_defines.svh"

module bba_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bba_pkg::CNT_W-1:0]           count,
    bba_req_if.sink                             req,
    bba_rsp_if.source                           rsp,
    output logic [bba_pkg::WORD_ADDR_W-1:0]     rd_addr,
    input  logic [bba_pkg::WORD_BITS-1:0]       rd_data,
    output bba_pkg::bba_wr_t                    wr
);

    bba_pkg::bba_state_t                 state_reg, state_next;
    logic [bba_pkg::WORD_ADDR_W-1:0]     word_idx_reg, word_idx_next;
    logic [bba_pkg::IDX_W-1:0]           fidx_reg, fidx_next;
    logic                                out_valid_reg, out_valid_next;
    logic [bba_pkg::IDX_W-1:0]           out_index_reg, out_index_next;
    bba_pkg::bba_status_t                out_status_reg, out_status_next;

    logic [bba_pkg::CNT_W-1:0]           base;
    logic [bba_pkg::CNT_W-1:0]           remain;
    logic [bba_pkg::WORD_BITS-1:0]       limit_mask;
    logic [bba_pkg::WORD_BITS-1:0]       cand;
    logic                                found;
    logic [bba_pkg::BIT_W-1:0]           bit_idx;
    logic                                last_word;
    logic                                out_free;
    logic                                in_range;

    // bits of the current word that lie below the block count
    assign base   = bba_pkg::CNT_W'({word_idx_reg, {bba_pkg::BIT_W{1'b0}}});
    assign remain = (count > base) ? (count - base) : '0;

    always_comb
    begin
        for (int b = 0; b < bba_pkg::WORD_BITS; b++)
        begin
            limit_mask[b] = (bba_pkg::CNT_W'(b) < remain);
        end
    end

    assign cand = ~rd_data & limit_mask;

    bba_first_free u_first_free (
        .cand    (cand),
        .found   (found),
        .bit_idx (bit_idx)
    );

    assign last_word = (word_idx_reg == bba_pkg::WORD_ADDR_W'(bba_pkg::NUM_WORDS - 1))
                    || ((base + bba_pkg::CNT_W'(bba_pkg::WORD_BITS)) >= count);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign in_range  = (bba_pkg::CNT_W'(fidx_reg) < count);
    assign rd_addr   = word_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_idx_reg   <= word_idx_next;
        fidx_reg       <= fidx_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        word_idx_next   = word_idx_reg;
        fidx_next       = fidx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        wr              = '0;
        req.ready       = 1'b0;

        case (state_reg)
            bba_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    fidx_next     = req.free_index;
                    word_idx_next = '0;
                    state_next    = (req.req_type == bba_pkg::REQ_FREE) ? bba_pkg::ST_FREE
                                                                        : bba_pkg::ST_SCAN;
                end
            end
            bba_pkg::ST_SCAN:
            begin
                if (found || last_word)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        if (found)
                        begin
                            wr.en           = 1'b1;
                            wr.set          = 1'b1;
                            wr.addr         = word_idx_reg;
                            wr.bit_idx      = bit_idx;
                            out_index_next  = bba_pkg::IDX_W'({word_idx_reg, bit_idx});
                            out_status_next = bba_pkg::STATUS_OK;
                        end
                        else
                        begin
                            out_index_next  = '0;
                            out_status_next = bba_pkg::STATUS_FULL;
                        end
                        state_next = bba_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    word_idx_next = word_idx_reg + bba_pkg::WORD_ADDR_W'(1);
                end
            end
            bba_pkg::ST_FREE:
            begin
                if (out_free)
                begin
                    wr.en           = in_range;
                    wr.set          = 1'b0;
                    wr.addr         = fidx_reg[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
                    wr.bit_idx      = fidx_reg[bba_pkg::BIT_W-1:0];
                    out_valid_next  = 1'b1;
                    out_index_next  = '0;
                    out_status_next = in_range ? bba_pkg::STATUS_OK : bba_pkg::STATUS_RANGE;
                    state_next      = bba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_index = out_index_reg;
    assign rsp.status        = out_status_reg;

    `BBA_ASSERT_IMP(a_grant_below_count, wr.en && wr.set,
        bba_pkg::CNT_W'({wr.addr, wr.bit_idx}) < count)
    `BBA_ASSERT_NEXT(a_grant_reported, state_reg == bba_pkg::ST_SCAN && found && out_free,
        rsp.valid && rsp.status == bba_pkg::STATUS_OK)
    `BBA_ASSERT_IMP(a_fail_index_zero, rsp.valid && rsp.status != bba_pkg::STATUS_OK,
        rsp.granted_index == '0)

endmodule

// File: design/block_bitmap_allocator.sv
// top level of the block bitmap allocator
//
//   port          dir   handshake        word
//   req           in    valid / ready    req_type, free_index
//   rsp           out   valid / ready    granted_index, status
//   cfg_wr_*      in    write enable     block count (11 bits)
//
// an allocate scans one bitmap word per cycle through a single first-free
// encoder, up to 32 words, and its result is registered on a hit or at the last word
// a free is registered from ST_FREE after accept; a request is taken only in
// ST_IDLE, so a new request waits until the last one has finished
// a stalled rsp holds the result and a finished request waits behind it
// reset clears the whole bitmap at once and sets the block count to 1024
module block_bitmap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bba_pkg::CNT_W-1:0]     cfg_wr_data,
    bba_req_if.sink                       req,
    bba_rsp_if.source                     rsp
);

    logic [bba_pkg::CNT_W-1:0]       count_reg;
    logic [bba_pkg::CNT_W-1:0]       count_eff;
    logic [bba_pkg::WORD_ADDR_W-1:0] rd_addr;
    logic [bba_pkg::WORD_BITS-1:0]   rd_data;
    bba_pkg::bba_wr_t                wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= bba_pkg::COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    // saturate the block count to the bitmap size
    assign count_eff = (count_reg > bba_pkg::COUNT_MAX) ? bba_pkg::COUNT_MAX : count_reg;

    bba_word_store u_word_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    bba_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .count   (count_eff),
        .req     (req),
        .rsp     (rsp),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

endmodule

// File: tb/block_bitmap_allocator_tb.sv
// testbench for the block bitmap allocator: directed table, then random traffic
`timescale 1ns / 1ps

module block_bitmap_allocator_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [bba_pkg::IDX_W-1:0] granted_index;
        bba_pkg::bba_status_t      status;
    } grant_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic                      req_type;
        logic [bba_pkg::IDX_W-1:0] free_index;
        logic [bba_pkg::CNT_W-1:0] cfg_value;
        logic                      checked;
        logic [bba_pkg::IDX_W-1:0] exp_index;
        bba_pkg::bba_status_t      exp_status;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [bba_pkg::CNT_W-1:0] cfg_wr_data;

    bba_req_if req_bus ();
    bba_rsp_if rsp_bus ();

    block_bitmap_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_bus),
        .rsp         (rsp_bus)
    );

    logic [bba_pkg::MAX_BLOCKS-1:0] shadow_used;
    logic [bba_pkg::CNT_W-1:0]      shadow_count;
    grant_t                         pending_grants[$];
    grant_t                         want_grant;
    grant_t                         typed_grant;
    int                             mismatch_count;
    int                             cycle_count;
    int                             snd_idle_pct;
    int                             rcv_idle_pct;
    int                             random_sent;
    bit                             hold_trigger;
    int                             hold_count;

    script_row_t script [0:29] = '{
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b1, 10'd1, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd1023, 11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd0,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd1023, 11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd1,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_CFG, bba_pkg::REQ_ALLOC, 10'd0,    11'd1,    1'b0, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_FULL},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd1,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_RANGE},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd0,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_CFG, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b0, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_FULL},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd0,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_RANGE},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd1023, 11'd0,    1'b1, 10'd0, bba_pkg::STATUS_RANGE},
        '{ROW_CFG, bba_pkg::REQ_ALLOC, 10'd0,    11'd2047, 1'b0, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd1023, 11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b0, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b0, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_CFG, bba_pkg::REQ_ALLOC, 10'd0,    11'd3,    1'b0, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_FULL},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd2,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd3,    11'd0,    1'b1, 10'd0, bba_pkg::STATUS_RANGE},
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b1, 10'd2, bba_pkg::STATUS_OK},
        '{ROW_CFG, bba_pkg::REQ_ALLOC, 10'd0,    11'd1024, 1'b0, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_ALLOC, 10'd0,    11'd0,    1'b0, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd512,  11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd1023, 11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd341,  11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK},
        '{ROW_REQ, bba_pkg::REQ_FREE,  10'd682,  11'd0,    1'b1, 10'd0, bba_pkg::STATUS_OK}
    };

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int managed_blocks();
        if (shadow_count > bba_pkg::COUNT_MAX)
            return bba_pkg::MAX_BLOCKS;
        return int'(shadow_count);
    endfunction

    task automatic predict_grant(input logic rt, input logic [bba_pkg::IDX_W-1:0] idx,
                                 output grant_t g);
        int lim;
        lim = managed_blocks();
        g.granted_index = '0;
        if (rt == bba_pkg::REQ_ALLOC)
        begin
            g.status = bba_pkg::STATUS_FULL;
            for (int i = 0; i < lim; i++)
            begin
                if (!shadow_used[i])
                begin
                    shadow_used[i] = 1'b1;
                    g.granted_index = bba_pkg::IDX_W'(i);
                    g.status = bba_pkg::STATUS_OK;
                    break;
                end
            end
        end
        else if (int'(idx) < lim)
        begin
            shadow_used[idx] = 1'b0;
            g.status = bba_pkg::STATUS_OK;
        end
        else
        begin
            g.status = bba_pkg::STATUS_RANGE;
        end
    endtask

    task automatic issue_request(input logic rt, input logic [bba_pkg::IDX_W-1:0] idx,
                                 input logic typed, input grant_t typed_value);
        grant_t g;
        if ($urandom_range(99) < snd_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= rt;
        req_bus.free_index <= idx;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predict_grant(rt, idx, g);
        pending_grants.push_back(typed ? typed_value : g);
    endtask

    task automatic write_block_count(input logic [bba_pkg::CNT_W-1:0] value);
        req_bus.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        shadow_count = value;
    endtask

    task automatic run_phase(input logic [bba_pkg::CNT_W-1:0] count, input int n_items,
                             input int alloc_pct, input int hold_at);
        logic                      rt;
        logic [bba_pkg::IDX_W-1:0] idx;
        int                        lim;
        int                        pick;
        grant_t                    unused;
        write_block_count(count);
        lim = managed_blocks();
        unused = '0;
        for (int k = 0; k < n_items; k++)
        begin
            if (random_sent < 600)
            begin
                snd_idle_pct = 35;
                rcv_idle_pct = 52;
            end
            else if (random_sent < 1200)
            begin
                snd_idle_pct = 52;
                rcv_idle_pct = 35;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            if (k == hold_at)
                hold_trigger <= 1'b1;
            idx = bba_pkg::IDX_W'($urandom);
            if ($urandom_range(99) < alloc_pct)
            begin
                rt = bba_pkg::REQ_ALLOC;
            end
            else
            begin
                rt = bba_pkg::REQ_FREE;
                pick = $urandom_range(99);
                if (pick < 75 && lim > 0)
                    idx = bba_pkg::IDX_W'($urandom_range(lim - 1));
                else if (pick < 85 && lim < bba_pkg::MAX_BLOCKS)
                    idx = bba_pkg::IDX_W'(lim);
            end
            issue_request(rt, idx, 1'b0, unused);
            random_sent++;
        end
    endtask

    // response side: random stalls, one long hold-off, and the check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual index %0d status %0d",
                             $time, rsp_bus.granted_index, rsp_bus.status);
                    mismatch_count++;
                end
                else
                begin
                    want_grant = pending_grants.pop_front();
                    if (rsp_bus.granted_index !== want_grant.granted_index)
                    begin
                        $display("%0t: granted_index expected %0d actual %0d",
                                 $time, want_grant.granted_index, rsp_bus.granted_index);
                        mismatch_count++;
                    end
                    if (rsp_bus.status !== want_grant.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want_grant.status, rsp_bus.status);
                        mismatch_count++;
                    end
                end
            end
            if (hold_trigger && hold_count < HOLD_CYCLES)
            begin
                hold_count++;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = bba_pkg::REQ_ALLOC;
        req_bus.free_index = '0;
        rsp_bus.ready      = 1'b0;
        shadow_used        = '0;
        shadow_count       = bba_pkg::COUNT_RESET;
        mismatch_count     = 0;
        cycle_count        = 0;
        snd_idle_pct       = 35;
        rcv_idle_pct       = 52;
        random_sent        = 0;
        hold_trigger       = 1'b0;
        hold_count         = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                write_block_count(script[i].cfg_value);
            end
            else
            begin
                typed_grant.granted_index = script[i].exp_index;
                typed_grant.status        = script[i].exp_status;
                issue_request(script[i].req_type, script[i].free_index,
                              script[i].checked, typed_grant);
            end
        end

        run_phase(11'd40, 150, 60, -1);
        run_phase(11'd0, 20, 50, -1);
        run_phase(11'd1, 30, 50, -1);
        run_phase(11'd2047, 100, 55, -1);
        run_phase(11'd100, 200, 65, 60);
        run_phase(11'd33, 150, 55, -1);
        // large count, mostly allocates, so the map fills and reports full
        run_phase(11'd1024, 1150, 95, -1);

        req_bus.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: block_bitmap_allocator.f
+incdir+design
design/bba_pkg.sv
design/bba_req_if.sv
design/bba_rsp_if.sv
design/bba_word_store.sv
design/bba_first_free.sv
design/bba_seq.sv
design/block_bitmap_allocator.sv
tb/block_bitmap_allocator_tb.sv
